/* design/coalescing_request_queue_defines.svh */
// Assertion macros for the coalescing request queue.
// Included by the top level; the macros expect clk and rst_n in scope.
`ifndef COALESCING_REQUEST_QUEUE_DEFINES_SVH
`define COALESCING_REQUEST_QUEUE_DEFINES_SVH

// same-cycle implication
`define CRQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crq assertion failed");

// next-cycle implication
`define CRQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crq assertion failed");

`endif

/* design/crq_pkg.sv */
// Shared types and constants of the coalescing request queue.
// No dependencies; used by crq_cell and coalescing_request_queue.
package crq_pkg;

  localparam int RING_DEPTH = 16;
  localparam int NUM_CELLS  = RING_DEPTH - 1;
  localparam int ID_BITS    = 8;
  localparam int VOL_BITS   = 8;

  localparam logic [VOL_BITS-1:0] VOLUME_MAX = VOL_BITS'(128);

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [2:0] {
    ST_APPENDED  = 3'd0,
    ST_MERGED    = 3'd1,
    ST_FULL      = 3'd2,
    ST_POPPED    = 3'd3,
    ST_POP_EMPTY = 3'd4
  } status_t;

  typedef struct packed {
    logic                valid;
    logic [ID_BITS-1:0]  id;
    logic [VOL_BITS-1:0] vol;
  } entry_t;

  typedef struct packed {
    logic                push_en;
    logic                pop_en;
    logic                hit_any;
    logic [ID_BITS-1:0]  id;
    logic [VOL_BITS-1:0] vol;
  } cell_ctrl_t;

endpackage

/* design/crq_cell.sv */
// One queue slot: holds an entry, matches the request id, shifts toward
// the head on pop and appends when it is the first free slot. Uses crq_pkg.
module crq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  crq_pkg::cell_ctrl_t ctrl_i,
  input  logic              left_valid_i,
  input  crq_pkg::entry_t   right_i,
  output crq_pkg::entry_t   entry_o,
  output logic              hit_o
);
  import crq_pkg::*;

  logic                valid_r, valid_nxt;
  logic [ID_BITS-1:0]  id_r, id_nxt;
  logic [VOL_BITS-1:0] vol_r, vol_nxt;

  assign hit_o   = valid_r && (id_r == ctrl_i.id);
  assign entry_o = '{valid: valid_r, id: id_r, vol: vol_r};

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    vol_nxt   = vol_r;
    if (ctrl_i.pop_en) begin
      valid_nxt = right_i.valid;
      id_nxt    = right_i.id;
      vol_nxt   = right_i.vol;
    end else if (ctrl_i.push_en) begin
      if (hit_o) begin
        if (ctrl_i.vol > vol_r) begin
          vol_nxt = ctrl_i.vol;
        end
      end else if (!ctrl_i.hit_any && !valid_r && left_valid_i) begin
        valid_nxt = 1'b1;
        id_nxt    = ctrl_i.id;
        vol_nxt   = ctrl_i.vol;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    vol_r <= vol_nxt;
  end

endmodule

/* design/coalescing_request_queue.sv */
// Coalescing request queue: a row of slot cells, head in cell 0.
// The result is registered in the cycle after a request is accepted; one request per
// cycle without back-pressure, bounded by the combinational id compare of all cells.
// Holds up to RING_DEPTH - 1 requests. Synchronous active-low reset empties
// the queue at once (valid bits only); no clearing pass.
module coalescing_request_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // mode[0], req_id[8:1], req_volume[16:9], zeros
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // status[2:0], out_id[10:3], out_volume[18:11], zeros
);
  import crq_pkg::*;
  `include "coalescing_request_queue_defines.svh"

  logic                mode;
  logic [7:0]          req_id;
  logic [7:0]          req_volume;
  logic [VOL_BITS-1:0] vol_sat;
  logic                in_fire;
  logic                full;
  logic                empty;
  logic                hit_any;
  logic [NUM_CELLS-1:0] cell_valid;
  logic [NUM_CELLS-1:0] hit_w;
  entry_t              entry_w [NUM_CELLS];
  cell_ctrl_t          ctrl;

  logic                out_valid_r, out_valid_nxt;
  status_t             status_r, status_nxt;
  logic [7:0]          out_id_r, out_id_nxt;
  logic [7:0]          out_volume_r, out_volume_nxt;

  assign mode       = in_tdata[0];
  assign req_id     = in_tdata[8:1];
  assign req_volume = in_tdata[16:9];
  assign vol_sat    = (req_volume > VOLUME_MAX) ? VOLUME_MAX : req_volume;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign hit_any   = |hit_w;
  assign full      = cell_valid[NUM_CELLS-1];
  assign empty     = !cell_valid[0];

  assign ctrl.push_en = in_fire && (mode == MODE_PUSH) && !full;
  assign ctrl.pop_en  = in_fire && (mode == MODE_POP) && !empty;
  assign ctrl.hit_any = hit_any;
  assign ctrl.id      = req_id[ID_BITS-1:0];
  assign ctrl.vol     = vol_sat;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    entry_t right_w;
    logic   left_w;
    if (i == NUM_CELLS - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid
      assign right_w = entry_w[i+1];
    end
    if (i == 0) begin : g_head
      assign left_w = 1'b1;
    end else begin : g_body
      assign left_w = entry_w[i-1].valid;
    end
    crq_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl_i       (ctrl),
      .left_valid_i (left_w),
      .right_i      (right_w),
      .entry_o      (entry_w[i]),
      .hit_o        (hit_w[i])
    );
    assign cell_valid[i] = entry_w[i].valid;
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_tready;
    status_nxt     = status_r;
    out_id_nxt     = out_id_r;
    out_volume_nxt = out_volume_r;
    if (in_fire) begin
      out_valid_nxt  = 1'b1;
      out_id_nxt     = '0;
      out_volume_nxt = '0;
      if (mode == MODE_PUSH) begin
        if (full) begin
          status_nxt = ST_FULL;
        end else if (hit_any) begin
          status_nxt = ST_MERGED;
        end else begin
          status_nxt = ST_APPENDED;
        end
      end else if (empty) begin
        status_nxt = ST_POP_EMPTY;
      end else begin
        status_nxt     = ST_POPPED;
        out_id_nxt     = 8'(entry_w[0].id);
        out_volume_nxt = 8'(entry_w[0].vol);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r     <= status_nxt;
    out_id_r     <= out_id_nxt;
    out_volume_r <= out_volume_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_volume_r, out_id_r, status_r};

  `CRQ_ASSERT_IMPL(a_valid_contiguous, 1'b1, ((cell_valid + 1'b1) & cell_valid) == '0)
  `CRQ_ASSERT_NEXT(a_append_grows, ctrl.push_en && !hit_any,
    $countones(cell_valid) == $past($countones(cell_valid)) + 1)
  `CRQ_ASSERT_NEXT(a_merge_keeps, ctrl.push_en && hit_any,
    cell_valid == $past(cell_valid))
  `CRQ_ASSERT_IMPL(a_push_zero_payload, out_valid_r && (status_r != ST_POPPED),
    (out_id_r == '0) && (out_volume_r == '0))

endmodule

/* verif/tb_coalescing_request_queue.sv */
// Self-checking testbench for coalescing_request_queue: directed requests, then random
// push/pop traffic with random stalls on both sides, checked against a queue predictor.
// Depends on crq_pkg and the coalescing_request_queue RTL.
module tb_coalescing_request_queue;
  import crq_pkg::*;

  localparam int N_DIRECTED = 24;
  localparam int N_RANDOM   = 426;
  localparam int N_TOTAL    = N_DIRECTED + N_RANDOM;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    status_t             st;
    logic [ID_BITS-1:0]  oid;
    logic [VOL_BITS-1:0] ovol;
  } play_result_t;

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [VOL_BITS-1:0] vol;
  } queued_play_t;

  typedef struct packed {
    logic                mode;
    logic [ID_BITS-1:0]  id;
    logic [VOL_BITS-1:0] vol;
    logic                typed;
    play_result_t        want;
  } play_vec_t;

  // typed rows: after reset, extremes, saturation, full ring; others go through the predictor
  localparam play_vec_t DIRECTED [N_DIRECTED] = '{
    '{MODE_POP,  8'h00, 8'h00, 1'b1, '{ST_POP_EMPTY, 8'h00, 8'h00}},
    '{MODE_PUSH, 8'h00, 8'h00, 1'b1, '{ST_APPENDED,  8'h00, 8'h00}},
    '{MODE_PUSH, 8'hFF, 8'd128, 1'b1, '{ST_APPENDED, 8'h00, 8'h00}},
    '{MODE_PUSH, 8'hFF, 8'hFF, 1'b1, '{ST_MERGED,    8'h00, 8'h00}},
    '{MODE_PUSH, 8'h00, 8'd5,  1'b1, '{ST_MERGED,    8'h00, 8'h00}},
    '{MODE_POP,  8'hFF, 8'hFF, 1'b1, '{ST_POPPED,    8'h00, 8'd5}},
    '{MODE_POP,  8'h00, 8'h00, 1'b1, '{ST_POPPED,    8'hFF, 8'd128}},
    '{MODE_POP,  8'h00, 8'h00, 1'b1, '{ST_POP_EMPTY, 8'h00, 8'h00}},
    '{MODE_PUSH, 8'h10, 8'd1,   1'b0, '{ST_APPENDED, 8'h00, 8'h00}},
    '{MODE_PUSH, 8'h11, 8'd9,   1'b0, '{ST_APPENDED, 8'h00, 8'h00}},
    '{MODE_PUSH, 8'h12, 8'd17,  1'b0, '{ST_APPENDED, 8'h00, 8'h00}},
    '{MODE_PUSH, 8'h13, 8'd25,  1'b0, '{ST_APPENDED, 8'h00, 8'h00}},
    '{MODE_PUSH, 8'h14, 8'd33,  1'b0, '{ST_APPENDED, 8'h00, 8'h00}},
    '{MODE_PUSH, 8'h15, 8'd41,  1'b0, '{ST_APPENDED, 8'h00, 8'h00}},
    '{MODE_PUSH, 8'h16, 8'd49,  1'b0, '{ST_APPENDED, 8'h00, 8'h00}},
    '{MODE_PUSH, 8'h17, 8'd57,  1'b0, '{ST_APPENDED, 8'h00, 8'h00}},
    '{MODE_PUSH, 8'h18, 8'd65,  1'b0, '{ST_APPENDED, 8'h00, 8'h00}},
    '{MODE_PUSH, 8'h19, 8'd73,  1'b0, '{ST_APPENDED, 8'h00, 8'h00}},
    '{MODE_PUSH, 8'h1A, 8'd81,  1'b0, '{ST_APPENDED, 8'h00, 8'h00}},
    '{MODE_PUSH, 8'h1B, 8'd89,  1'b0, '{ST_APPENDED, 8'h00, 8'h00}},
    '{MODE_PUSH, 8'h1C, 8'd97,  1'b0, '{ST_APPENDED, 8'h00, 8'h00}},
    '{MODE_PUSH, 8'h1D, 8'd105, 1'b0, '{ST_APPENDED, 8'h00, 8'h00}},
    '{MODE_PUSH, 8'h1E, 8'd113, 1'b0, '{ST_APPENDED, 8'h00, 8'h00}},
    '{MODE_PUSH, 8'h10, 8'd128, 1'b1, '{ST_FULL,     8'h00, 8'h00}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  queued_play_t play_queue[$];
  play_result_t results_due[$];
  int           mismatches = 0;
  int           stall_pct = 0;

  coalescing_request_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(12 * 200000);
    $display("TB_ERROR");
    $finish;
  end

  function automatic play_result_t play_queue_step(logic mode, logic [ID_BITS-1:0] id,
                                                   logic [VOL_BITS-1:0] vol);
    play_result_t        r;
    queued_play_t        head;
    logic [VOL_BITS-1:0] v;
    bit                  hit;
    r.st = ST_APPENDED;
    r.oid = '0;
    r.ovol = '0;
    v = (vol > VOLUME_MAX) ? VOLUME_MAX : vol;
    hit = 1'b0;
    if (mode == MODE_PUSH) begin
      if (play_queue.size() == RING_DEPTH - 1) begin
        r.st = ST_FULL;
      end else begin
        foreach (play_queue[i]) begin
          if (!hit && play_queue[i].id == id) begin
            if (v > play_queue[i].vol) play_queue[i].vol = v;
            hit = 1'b1;
          end
        end
        if (hit) begin
          r.st = ST_MERGED;
        end else begin
          play_queue.push_back('{id, v});
        end
      end
    end else if (play_queue.size() == 0) begin
      r.st = ST_POP_EMPTY;
    end else begin
      head = play_queue.pop_front();
      r.st = ST_POPPED;
      r.oid = head.id;
      r.ovol = head.vol;
    end
    return r;
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // request side
  initial begin
    play_vec_t           cur;
    play_result_t        predicted;
    logic [ID_BITS-1:0]  id_base;
    bit                  offering;
    int                  sent;
    int                  gap_pct;
    int                  pop_pct;
    int                  k;
    int                  phase;
    offering = 1'b0;
    sent = 0;
    gap_pct = 0;
    id_base = '0;
    cur = '0;
    wait (rst_n);
    while (sent < N_TOTAL) begin
      @(posedge clk);
      if (in_tvalid && in_tready) begin
        predicted = play_queue_step(cur.mode, cur.id, cur.vol);
        results_due.push_back(cur.typed ? cur.want : predicted);
        sent++;
        offering = 1'b0;
      end
      phase = (sent < N_DIRECTED) ? 0 : ((sent - N_DIRECTED) / 50) % 4;
      case (phase)
        0: begin gap_pct = 0;  stall_pct <= 0;  end
        1: begin gap_pct = 48; stall_pct <= 0;  end
        2: begin gap_pct = 0;  stall_pct <= 48; end
        default: begin gap_pct = 22; stall_pct <= 22; end
      endcase
      if (!offering && sent < N_TOTAL && $urandom_range(99) >= gap_pct) begin
        if (sent < N_DIRECTED) begin
          cur = DIRECTED[sent];
        end else begin
          k = sent - N_DIRECTED;
          if (k % 40 == 0) id_base = ID_BITS'($urandom_range(255));
          // bursts: push-heavy fills the ring, pop-heavy drains it
          pop_pct = (k / 40) % 3 == 0 ? 20 : ((k / 40) % 3 == 1 ? 65 : 40);
          cur = '0;
          cur.mode = ($urandom_range(99) < pop_pct) ? MODE_POP : MODE_PUSH;
          cur.id = ($urandom_range(9) < 7) ? id_base + ID_BITS'($urandom_range(19))
                                           : ID_BITS'($urandom_range(255));
          cur.vol = ($urandom_range(9) < 8) ? VOL_BITS'($urandom_range(128))
                                            : VOL_BITS'($urandom_range(255, 129));
        end
        offering = 1'b1;
      end
      in_tvalid <= offering;
      in_tdata <= {7'b0, cur.vol, cur.id, cur.mode};
    end
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // result side, with one long hold-off to back up the block
  initial begin
    int cycles;
    int hold_left;
    bit held;
    cycles = 0;
    hold_left = 0;
    held = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      cycles++;
      if (!held && cycles == 400) begin
        hold_left = 80;
        held = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    play_result_t want;
    play_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.st = status_t'(out_tdata[2:0]);
      got.oid = out_tdata[10:3];
      got.ovol = out_tdata[18:11];
      if (results_due.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: status %0d id %0h vol %0d",
                   got.st, got.oid, got.ovol);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (got.st !== want.st || got.oid !== want.oid || got.ovol !== want.ovol) begin
          if (mismatches < MAX_REPORTS)
            $display("mismatch: expected status %0d id %0h vol %0d, got status %0d id %0h vol %0d",
                     want.st, want.oid, want.ovol, got.st, got.oid, got.ovol);
          mismatches++;
        end
      end
    end
  end

endmodule

/* filelist.f */
+incdir+design
design/crq_pkg.sv
design/crq_cell.sv
design/coalescing_request_queue.sv
verif/tb_coalescing_request_queue.sv
